[hw/rtl/tga_rle_pkg.sv]
// ----------------------------------------------------------------------------
// tga_rle_pkg
// Shared types and constants for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_BPP        = 2'd0,
    REG_RLE_ENABLE = 2'd1,
    REG_IMG_PIXELS = 2'd2
  } cfg_reg_t;

  // effective pixel format, coded as bytes per pixel minus one
  typedef enum logic [1:0] {
    FMT_GREY  = 2'd0,
    FMT_1555  = 2'd1,
    FMT_BGR   = 2'd2,
    FMT_BGRA  = 2'd3
  } pix_fmt_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IMG_CNT_W  = 32;

  localparam logic [2:0] BPP_RESET = 3'd3;
  localparam logic [6:0] HDR_COUNT_MASK = 7'h7f;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] run_length;
    logic       last_of_image;
  } pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

endpackage

[hw/rtl/tga_rle_if.sv]
// ----------------------------------------------------------------------------
// tga_rle_if
// Valid/ready channels: image-data bytes in, decoded pixel runs out.
// ----------------------------------------------------------------------------
interface tga_rle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tga_rle_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] run_length;
  logic       last_of_image;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output run_length, output last_of_image, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input run_length, input last_of_image, output ready);
endinterface

[hw/rtl/tga_rle_cvt.sv]
// ----------------------------------------------------------------------------
// tga_rle_cvt
// Converts one assembled pixel (grey, ARGB1555, BGR, BGRA) to RGBA8.
// ----------------------------------------------------------------------------
module tga_rle_cvt
  import tga_rle_pkg::*;
(
  input  pix_fmt_t         fmt,
  input  logic [3:0][7:0]  pix_bytes,
  output rgba_t            rgba
);

  logic [15:0] word16;

  assign word16 = {pix_bytes[1], pix_bytes[0]};

  always_comb begin
    rgba = '0;
    case (fmt)
      FMT_GREY: begin
        rgba.red = pix_bytes[0];
      end
      FMT_1555: begin
        rgba.red   = {word16[14:10], 3'b000};
        rgba.green = {word16[9:5], 3'b000};
        rgba.blue  = {word16[4:0], 3'b000};
        rgba.alpha = word16[15] ? ALPHA_OPAQUE : 8'h00;
      end
      FMT_BGR: begin
        rgba.red   = pix_bytes[2];
        rgba.green = pix_bytes[1];
        rgba.blue  = pix_bytes[0];
        rgba.alpha = ALPHA_OPAQUE;
      end
      default: begin
        rgba.red   = pix_bytes[2];
        rgba.green = pix_bytes[1];
        rgba.blue  = pix_bytes[0];
        rgba.alpha = pix_bytes[3];
      end
    endcase
  end

endmodule

[hw/rtl/tga_rle_ctrl.sv]
// ----------------------------------------------------------------------------
// tga_rle_ctrl
// Packet parsing, pixel byte assembly and image pixel countdown.
// ----------------------------------------------------------------------------
module tga_rle_ctrl
  import tga_rle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  output logic                  res_valid,
  output pix_t                  res
);

  logic [2:0]           bpp_r, bpp_nxt;
  logic                 rle_r, rle_nxt;
  logic [IMG_CNT_W-1:0] img_left_r, img_left_nxt;
  logic                 hdr_r, hdr_nxt;
  logic                 rep_r, rep_nxt;
  logic [7:0]           pkt_left_r, pkt_left_nxt;
  logic [1:0]           bip_r, bip_nxt;
  logic [3:0][7:0]      pb_r, pb_nxt;
  logic [7:0]           run;
  logic                 last;
  pix_fmt_t             fmt;
  rgba_t                rgba;

  // out-of-range sizes clamp to grey or BGRA
  always_comb begin
    case (bpp_r)
      3'd0, 3'd1: fmt = FMT_GREY;
      3'd2:       fmt = FMT_1555;
      3'd3:       fmt = FMT_BGR;
      default:    fmt = FMT_BGRA;
    endcase
  end

  always_comb begin
    bpp_nxt      = bpp_r;
    rle_nxt      = rle_r;
    img_left_nxt = img_left_r;
    hdr_nxt      = hdr_r;
    rep_nxt      = rep_r;
    pkt_left_nxt = pkt_left_r;
    bip_nxt      = bip_r;
    pb_nxt       = pb_r;
    res_valid    = 1'b0;
    run          = 8'd1;
    last         = 1'b0;
    if (cfg_we && (cfg_index inside {REG_BPP, REG_RLE_ENABLE, REG_IMG_PIXELS})) begin
      case (cfg_index)
        REG_BPP:        bpp_nxt = cfg_data[2:0];
        REG_RLE_ENABLE: rle_nxt = cfg_data[0];
        default:        img_left_nxt = cfg_data[IMG_CNT_W-1:0];
      endcase
      hdr_nxt      = 1'b1;
      rep_nxt      = 1'b0;
      pkt_left_nxt = '0;
      bip_nxt      = '0;
    end else if (accept && (img_left_r != '0)) begin
      if (rle_r && hdr_r) begin
        rep_nxt      = data_byte[7];
        pkt_left_nxt = {1'b0, data_byte[6:0] & HDR_COUNT_MASK} + 8'd1;
        hdr_nxt      = 1'b0;
        bip_nxt      = '0;
      end else begin
        pb_nxt[bip_r] = data_byte;
        if (bip_r != fmt) begin
          bip_nxt = bip_r + 2'd1;
        end else begin
          bip_nxt   = '0;
          res_valid = 1'b1;
          if (rle_r && rep_r) begin
            // clip the run at the image end
            if (img_left_r < {{(IMG_CNT_W-8){1'b0}}, pkt_left_r}) begin
              run = img_left_r[7:0];
            end else begin
              run = pkt_left_r;
            end
            pkt_left_nxt = '0;
            hdr_nxt      = 1'b1;
          end else if (rle_r) begin
            pkt_left_nxt = pkt_left_r - 8'd1;
            if (pkt_left_r == 8'd1) begin
              hdr_nxt = 1'b1;
            end
          end
          img_left_nxt = img_left_r - {{(IMG_CNT_W-8){1'b0}}, run};
          last         = (img_left_r == {{(IMG_CNT_W-8){1'b0}}, run});
        end
      end
    end
  end

  tga_rle_cvt u_cvt (
    .fmt       (fmt),
    .pix_bytes (pb_nxt),
    .rgba      (rgba)
  );

  assign res.red           = rgba.red;
  assign res.green         = rgba.green;
  assign res.blue          = rgba.blue;
  assign res.alpha         = rgba.alpha;
  assign res.run_length    = run;
  assign res.last_of_image = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r      <= BPP_RESET;
      rle_r      <= 1'b0;
      img_left_r <= '0;
      hdr_r      <= 1'b1;
      rep_r      <= 1'b0;
      pkt_left_r <= '0;
      bip_r      <= '0;
    end else begin
      bpp_r      <= bpp_nxt;
      rle_r      <= rle_nxt;
      img_left_r <= img_left_nxt;
      hdr_r      <= hdr_nxt;
      rep_r      <= rep_nxt;
      pkt_left_r <= pkt_left_nxt;
      bip_r      <= bip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pb_r <= pb_nxt;
  end

`ifndef SYNTHESIS
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.run_length != 8'd0))
    else $error("pixel run of length zero");

  a_run_fits: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> ({{(IMG_CNT_W-8){1'b0}}, res.run_length} <= img_left_r))
    else $error("run exceeds pixels left in image");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.last_of_image && !cfg_we) |=> (img_left_r == '0))
    else $error("last pixel did not empty the image count");

  a_bip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg_we && (img_left_r != '0) && !(rle_r && hdr_r) && (bip_r == fmt))
    |=> (bip_r == '0))
    else $error("byte index not reset after last pixel byte");
`endif

endmodule

[hw/rtl/tga_rle_obuf.sv]
// ----------------------------------------------------------------------------
// tga_rle_obuf
// Two-entry output register with skid slot for decoded pixel results.
// ----------------------------------------------------------------------------
module tga_rle_obuf
  import tga_rle_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  pix_t push_data,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output pix_t out_data
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  pix_t out_data_r, out_data_nxt;
  pix_t skid_data_r, skid_data_nxt;
  logic pop;

  assign pop       = out_valid_r && out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        // advance the skid entry to the head
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

`ifndef SYNTHESIS
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a head entry");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("result pushed into a full buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry lost on transfer");
`endif

endmodule

[hw/rtl/tga_rle_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// TGA image-data decoder: run-length packets and raw pixels to RGBA8 runs.
// ----------------------------------------------------------------------------
// Takes one image-data byte per clock and, once a pixel's last byte arrives,
// delivers one RGBA8 result carrying the number of image pixels it covers
// (the whole run of a repeat packet, clipped at the image end, or one pixel).
// Every byte is handled in the cycle it is accepted: packet header and pixel
// byte counters, a four-byte pixel register and the 32-bit image countdown are
// updated by one level of logic, and the converted pixel is written into a
// two-entry output register, so a byte can be taken in every cycle and
// results leave from its head entry. Input stalls only while both
// output entries are full. Writing image_pixels starts an image; any register
// write restarts packet parsing. Bytes that arrive while no pixels are left
// are taken and dropped. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder
  import tga_rle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tga_rle_byte_if.sink          in_byte,
  tga_rle_pix_if.source         out_pix
);

  logic accept;
  logic space;
  logic res_valid;
  pix_t res;
  pix_t out_data;

  assign in_byte.ready = space;
  assign accept        = in_byte.valid && space;

  tga_rle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (in_byte.data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  tga_rle_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_pix.valid),
    .out_ready (out_pix.ready),
    .out_data  (out_data)
  );

  assign out_pix.red           = out_data.red;
  assign out_pix.green         = out_data.green;
  assign out_pix.blue          = out_data.blue;
  assign out_pix.alpha         = out_data.alpha;
  assign out_pix.run_length    = out_data.run_length;
  assign out_pix.last_of_image = out_data.last_of_image;

endmodule
